@@ src/skt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// skt_pkg
// shared constants and types of the streaming k-th largest tracker
// ----------------------------------------------------------------------------
package skt_pkg;

   localparam int MAX_K   = 64;
   localparam int ADDR_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int CNT_W   = $clog2(MAX_K + 1);
   localparam int RANK_W  = 7;
   localparam int DATA_W  = 32;
   localparam int EXT_W   = CNT_W + RANK_W;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_TAIL_CMP = 7'b0000010,
      ST_STEP     = 7'b0000100,
      ST_STEP_CMP = 7'b0001000,
      ST_RES_RD   = 7'b0010000,
      ST_RES_OUT  = 7'b0100000,
      ST_SPARE    = 7'b1000000
   } state_type;

   // rank 0 reads as 1, ranks above the store depth saturate
   function automatic logic [CNT_W-1:0] eff_rank(input logic [RANK_W-1:0] rank);
      logic [EXT_W-1:0] r;
      logic [EXT_W-1:0] res;
      r = EXT_W'(rank);
      if (r == '0)
         res = EXT_W'(1);
      else if (r > EXT_W'(MAX_K))
         res = EXT_W'(MAX_K);
      else
         res = r;
      return res[CNT_W-1:0];
   endfunction

endpackage
`default_nettype wire

@@ src/streaming_kth_largest_tracker_unit.sv @@
`default_nettype none
// insertion: a value that is discarded skips the shifts; otherwise stored entries
//   smaller than the new value move down one slot at a time, each shift a read
//   (ST_STEP) and then a compare and write (ST_STEP_CMP) on the sorted value store
// throughput: one request at a time, the next accepted once the result is loaded
// reset: synchronous, empties the store (count cleared) and sets the rank (rank_ff) to 1
// ----------------------------------------------------------------------------
// streaming_kth_largest_tracker_unit
// keeps the k largest values of a signed stream in a sorted store, returns
// the smallest kept value and a full flag after every request
// ----------------------------------------------------------------------------
module streaming_kth_largest_tracker_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic signed [skt_pkg::DATA_W-1:0] req_new_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [skt_pkg::DATA_W-1:0] rsp_kth_value,
   output logic                             rsp_full_res,
   input  wire logic                        csr_wr_en,
   input  wire logic [skt_pkg::RANK_W-1:0]  csr_wr_data
);
   import skt_pkg::*;

   state_type state_ff, state_in;
   logic [RANK_W-1:0]        rank_ff, rank_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [ADDR_W-1:0]        pos_ff, pos_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic                     full_ff, full_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_full_ff, rsp_full_in;

   logic signed [DATA_W-1:0] mem [MAX_K];
   logic signed [DATA_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic signed [DATA_W-1:0] wr_data;

   logic [CNT_W-1:0] k_eff;
   logic [CNT_W-1:0] cnt_clip;
   logic [CNT_W-1:0] cnt_dec;
   logic [CNT_W-1:0] count_dec;
   logic             accept;
   logic             out_free;

   assign k_eff     = eff_rank(rank_ff);
   assign cnt_clip  = (count_ff > k_eff) ? k_eff : count_ff;
   assign cnt_dec   = cnt_clip - CNT_W'(1);
   assign count_dec = count_ff - CNT_W'(1);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kth_value = rsp_value_ff;
   assign rsp_full_res  = rsp_full_ff;

   // sorted store, descending, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      rank_in      = csr_wr_en ? csr_wr_data : rank_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      value_in     = value_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_full_in  = rsp_full_ff;
      rd_addr      = count_dec[ADDR_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = value_ff;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = cnt_dec[ADDR_W-1:0];
            if (accept) begin
               value_in = req_new_value;
               if (cnt_clip < k_eff) begin
                  // room left, insert with the store growing by one
                  count_in = cnt_clip + CNT_W'(1);
                  full_in  = ((cnt_clip + CNT_W'(1)) == k_eff);
                  pos_in   = cnt_clip[ADDR_W-1:0];
                  state_in = ST_STEP;
               end else begin
                  // full, compare against the smallest kept value first
                  count_in = cnt_clip;
                  full_in  = 1'b1;
                  pos_in   = cnt_dec[ADDR_W-1:0];
                  state_in = ST_TAIL_CMP;
               end
            end
         end
         ST_TAIL_CMP: begin
            if (value_ff > rd_data_ff)
               state_in = ST_STEP;
            else
               state_in = ST_RES_RD;
         end
         ST_STEP: begin
            rd_addr = pos_ff - ADDR_W'(1);
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = ST_RES_RD;
            end else begin
               state_in = ST_STEP_CMP;
            end
         end
         ST_STEP_CMP: begin
            wr_en = 1'b1;
            if (rd_data_ff < value_ff) begin
               // shift the smaller neighbor down one slot
               wr_data  = rd_data_ff;
               pos_in   = pos_ff - ADDR_W'(1);
               state_in = ST_STEP;
            end else begin
               state_in = ST_RES_RD;
            end
         end
         ST_RES_RD: begin
            state_in = ST_RES_OUT;
         end
         ST_RES_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_data_ff;
               rsp_full_in  = full_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rank_ff      <= RANK_W'(1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rank_ff      <= rank_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      value_ff     <= value_in;
      full_ff      <= full_in;
      rsp_value_ff <= rsp_value_in;
      rsp_full_ff  <= rsp_full_in;
   end

endmodule
`default_nettype wire
